/* design/qts_pkg.sv */
// Shared constants and types for the two-stack queue.
`default_nettype none

package qts_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int S_TDATA_W   = ((OP_W + DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W   = ((DATA_W + STATUS_W + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ENQUEUE = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQUEUE = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    // Per-cycle shift command for a stack chain; push and pop never together.
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

`default_nettype wire

/* design/queue_from_two_stacks_core.sv */
// Top level of the FIFO queue built from an input stack and an output stack.
//
// Input channel s_*: one item per command (enqueue, dequeue, peek front).
// Output channel m_*: exactly one result per item, in order.
// Each stack is a chain of STACK_DEPTH cells that shift together, cell 0 the top.
// Enqueue pushes onto the input stack; a full input stack answers overflow.
// Dequeue and peek on an empty output stack first move the input stack over,
// one entry per cycle (pop one chain, push the other), which reverses order.
// Sequence: an item is registered when taken and executed from S_EXEC; a
// refill starts at the check in S_EXEC, moves entries in S_XFER and then
// returns to S_EXEC. Every entry is moved over only once, so the refill
// work is spread across the items.
// s_tready is high whenever no item is in flight; it does not wait on m_tready,
// since the result sits in an output register. If that register is still full
// when the next result is due, execution waits until the receiver takes it.
// Reset clears both counts, the control state and the output valid; stack
// cells hold no reset value and are only ever read below a count.
`default_nettype none

module queue_from_two_stacks_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [qts_pkg::S_TDATA_W-1:0]   s_tdata,   // op[1:0], data[33:2], zero pad
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [qts_pkg::M_TDATA_W-1:0]   m_tdata    // value[31:0], status[33:32], pad
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_XFER = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [qts_pkg::OP_W-1:0]     op_reg;
    logic [qts_pkg::DATA_W-1:0]   data_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [qts_pkg::DATA_W-1:0]   value_reg;
    logic [qts_pkg::STATUS_W-1:0] status_reg;

    logic                         accept;
    logic                         out_free;
    logic                         load;
    logic [qts_pkg::DATA_W-1:0]   res_value;
    logic [qts_pkg::STATUS_W-1:0] res_status;

    qts_pkg::stk_ctrl_t           in_ctrl;
    qts_pkg::stk_ctrl_t           out_ctrl;
    logic [qts_pkg::DATA_W-1:0]   in_top;
    logic [qts_pkg::DATA_W-1:0]   out_top;
    logic [qts_pkg::CNT_W-1:0]    in_count;
    logic [qts_pkg::CNT_W-1:0]    out_count;
    logic                         in_full;
    logic                         in_empty;
    logic                         out_full;
    logic                         out_empty;
    logic                         is_read;

    qts_stack u_in_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (in_ctrl),
        .push_data (data_reg),
        .top_data  (in_top),
        .count     (in_count),
        .full      (in_full),
        .empty     (in_empty)
    );

    // Output stack is only pushed during a refill, from the input stack's top.
    qts_stack u_out_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (out_ctrl),
        .push_data (in_top),
        .top_data  (out_top),
        .count     (out_count),
        .full      (out_full),
        .empty     (out_empty)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign is_read  = (op_reg == qts_pkg::OP_DEQUEUE) || (op_reg == qts_pkg::OP_PEEK);

    always_comb
    begin
        state_next = state_reg;
        in_ctrl    = '0;
        out_ctrl   = '0;
        load       = 1'b0;
        res_value  = '0;
        res_status = qts_pkg::ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (is_read && out_empty && !in_empty)
                begin
                    state_next = S_XFER;
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == qts_pkg::OP_ENQUEUE)
                    begin
                        if (in_full)
                        begin
                            res_status = qts_pkg::ST_OVERFLOW;
                        end
                        else
                        begin
                            in_ctrl.push = 1'b1;
                        end
                    end
                    else if (is_read)
                    begin
                        if (out_empty)
                        begin
                            // both stacks empty here
                            res_value  = qts_pkg::EMPTY_VALUE;
                            res_status = qts_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            res_value    = out_top;
                            out_ctrl.pop = (op_reg == qts_pkg::OP_DEQUEUE);
                        end
                    end
                    // unused op code: no state change, zero result
                end
            end
            S_XFER:
            begin
                // output stack was empty, so it cannot overflow during a refill
                in_ctrl.pop   = 1'b1;
                out_ctrl.push = !out_full;
                if (in_count == qts_pkg::CNT_W'(1))
                begin
                    state_next = S_EXEC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tdata[qts_pkg::OP_W-1:0];
            data_reg <= s_tdata[qts_pkg::OP_W +: qts_pkg::DATA_W];
        end
        if (load)
        begin
            value_reg  <= res_value;
            status_reg <= res_status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = qts_pkg::M_TDATA_W'({status_reg, value_reg});

endmodule

`default_nettype wire

/* design/qts_cell.sv */
// One stack cell: holds one entry and shifts with its neighbors.
`default_nettype none

module qts_cell (
    input  wire logic                        clk,
    input  wire qts_pkg::stk_ctrl_t          ctrl,
    input  wire logic [qts_pkg::DATA_W-1:0]  up_data,    // neighbor toward the top
    input  wire logic [qts_pkg::DATA_W-1:0]  down_data,  // neighbor toward the bottom
    output logic      [qts_pkg::DATA_W-1:0]  q
);

    logic [qts_pkg::DATA_W-1:0] data_reg;
    logic [qts_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        if (ctrl.push)
        begin
            data_next = up_data;
        end
        else if (ctrl.pop)
        begin
            data_next = down_data;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

`default_nettype wire

/* design/qts_stack.sv */
// Stack built as a shift chain of cells; cell 0 is the top.
`default_nettype none

module qts_stack (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire qts_pkg::stk_ctrl_t          ctrl,
    input  wire logic [qts_pkg::DATA_W-1:0]  push_data,
    output logic      [qts_pkg::DATA_W-1:0]  top_data,
    output logic      [qts_pkg::CNT_W-1:0]   count,
    output logic                             full,
    output logic                             empty
);

    logic [qts_pkg::DATA_W-1:0] cell_q [qts_pkg::STACK_DEPTH];
    logic [qts_pkg::CNT_W-1:0]  count_reg;
    logic [qts_pkg::CNT_W-1:0]  count_next;

    for (genvar i = 0; i < qts_pkg::STACK_DEPTH; i++)
    begin : g_cell
        logic [qts_pkg::DATA_W-1:0] up_d;
        logic [qts_pkg::DATA_W-1:0] down_d;

        if (i == 0)
        begin : g_top
            assign up_d = push_data;
        end
        else
        begin : g_mid
            assign up_d = cell_q[i-1];
        end

        if (i == qts_pkg::STACK_DEPTH - 1)
        begin : g_bottom
            assign down_d = '0;
        end
        else
        begin : g_inner
            assign down_d = cell_q[i+1];
        end

        qts_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .up_data   (up_d),
            .down_data (down_d),
            .q         (cell_q[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.push)
        begin
            count_next = count_reg + qts_pkg::CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            count_next = count_reg - qts_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top_data = cell_q[0];
    assign count    = count_reg;
    assign full     = (count_reg == qts_pkg::CNT_W'(qts_pkg::STACK_DEPTH));
    assign empty    = (count_reg == '0);

endmodule

`default_nettype wire

/* design/qts_checker.sv */
// Port-level checker for the two-stack queue, bound to the top level.
`default_nettype none

module qts_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [qts_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [qts_pkg::M_TDATA_W-1:0]   m_tdata
);

    logic [qts_pkg::DATA_W-1:0]   value;
    logic [qts_pkg::STATUS_W-1:0] status;

    assign value  = m_tdata[qts_pkg::DATA_W-1:0];
    assign status = m_tdata[qts_pkg::DATA_W +: qts_pkg::STATUS_W];

    // a waiting result holds still
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty answer always carries -1
    a_empty_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == qts_pkg::ST_EMPTY) |-> value == qts_pkg::EMPTY_VALUE)
        else $error("empty status without -1 value");

    // an overflow answer always carries 0
    a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (status == qts_pkg::ST_OVERFLOW) |-> value == '0)
        else $error("overflow status with nonzero value");

    // ready input means nothing in flight; with no item taken, no result follows
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid && s_tready && !s_tvalid |=> !m_tvalid)
        else $error("result appeared without a pending item");

endmodule

bind queue_from_two_stacks_core qts_checker u_qts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
